// ===== rtl/ogru_pkg.sv =====
package ogru_pkg;

   localparam int HALF_CELLS = 127;
   localparam int SIDE       = 2 * HALF_CELLS + 1;
   localparam int NCELLS     = SIDE * SIDE;
   localparam int Q_ONE      = 65536;

   localparam int AXIS_W  = $clog2(SIDE);
   localparam int ADDR_W  = $clog2(NCELLS);
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int IDX_W   = COORD_W + 2;
   localparam int DVD_W   = DIFF_W + 16;
   localparam int DSR_W   = DIFF_W;
   localparam int SLOPE_W = 18;
   localparam int PROD_W  = SLOPE_W + IDX_W + 1;
   localparam int ACC_W   = PROD_W + 1;
   localparam int CNT_W   = 9;
   localparam int CSR_W   = 25;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
   localparam logic signed [7:0] CELL_FREE    = 8'sd0;
   localparam logic signed [7:0] CELL_OCC     = 8'sd100;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_STEP  = 2'd2;

   localparam logic OP_RAY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_COORD_GO,
      S_COORD_WAIT,
      S_AXIS,
      S_SLOPE_GO,
      S_SLOPE_WAIT,
      S_RANGE,
      S_MUL,
      S_ACC,
      S_WALK_RD,
      S_WALK_WR,
      S_HIT_RD,
      S_HIT_WR,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic clr_wr;
      logic coord_start;
      logic coord_store;
      logic axis;
      logic slope_start;
      logic slope_store;
      logic range;
      logic mul;
      logic acc_init;
      logic walk_rd;
      logic walk_adv;
      logic free_wr;
      logic hit_rd;
      logic hit_wr;
      logic read_rd;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic op_read;
      logic div_done;
      logic coord_last;
      logic degen;
      logic walk_empty;
      logic walk_last;
      logic cell_in;
      logic hit_in;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/ogru_div.sv =====
module ogru_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             long_run,
   input  logic [ogru_pkg::DVD_W-1:0]       dividend,
   input  logic [ogru_pkg::DSR_W-1:0]       divisor,
   output logic                             done,
   output logic [ogru_pkg::DVD_W-1:0]       quotient
);

   localparam int SHORT_N = ogru_pkg::COORD_W;
   localparam int LONG_N  = ogru_pkg::DVD_W;
   localparam int SHIFT_N = LONG_N - SHORT_N;
   localparam int ITER_W  = $clog2(LONG_N + 1);

   logic                          run_ff;
   logic [ITER_W-1:0]             cnt_ff;
   logic [ogru_pkg::DVD_W-1:0]    q_ff;
   logic [ogru_pkg::DSR_W-1:0]    r_ff;
   logic [ogru_pkg::DSR_W-1:0]    d_ff;
   logic [ogru_pkg::DSR_W:0]      trial;
   logic [ogru_pkg::DSR_W:0]      rem_wide;
   logic                          ge;

   always_comb begin
      trial    = {r_ff, q_ff[ogru_pkg::DVD_W-1]};
      ge       = trial >= {1'b0, d_ff};
      rem_wide = ge ? trial - {1'b0, d_ff} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && cnt_ff == ITER_W'(1)) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= long_run ? dividend : dividend << SHIFT_N;
         r_ff   <= '0;
         d_ff   <= divisor;
         cnt_ff <= long_run ? ITER_W'(LONG_N) : ITER_W'(SHORT_N);
      end else if (run_ff) begin
         q_ff   <= {q_ff[ogru_pkg::DVD_W-2:0], ge};
         r_ff   <= rem_wide[ogru_pkg::DSR_W-1:0];
         cnt_ff <= cnt_ff - ITER_W'(1);
      end
   end

   assign done     = ~run_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/ogru_dp.sv =====
module ogru_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ogru_pkg::cmd_type                    cmd,
   output ogru_pkg::status_type                 status,
   input  logic                                 req_op,
   input  logic signed [31:0]                   req_pose_x,
   input  logic signed [31:0]                   req_pose_y,
   input  logic signed [31:0]                   req_point_x,
   input  logic signed [31:0]                   req_point_y,
   input  logic [15:0]                          req_cell_index,
   input  logic                                 csr_wr_en,
   input  logic [ogru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ogru_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [7:0]                    rsp_cell_value,
   output logic [8:0]                           rsp_cells_updated,
   output logic                                 rsp_out_of_range
);

   localparam int IW = ogru_pkg::IDX_W;
   localparam int AW = ogru_pkg::AXIS_W;
   localparam int MW = ogru_pkg::ADDR_W;
   localparam int CW = ogru_pkg::ACC_W;
   localparam logic signed [IW-1:0] IDX_HALF = IW'(ogru_pkg::HALF_CELLS);
   localparam logic signed [IW-1:0] IDX_TOP  = IW'(ogru_pkg::SIDE - 1);
   localparam logic signed [IW-1:0] IDX_ONE  = IW'(1);
   localparam logic signed [CW-1:0] ACC_LOW  = CW'(-ogru_pkg::Q_ONE);
   localparam logic signed [CW-1:0] ACC_TOP  = CW'(ogru_pkg::SIDE * ogru_pkg::Q_ONE);

   // configuration
   logic [ogru_pkg::CSR_W-1:0]    cs_ff;
   logic [6:0]                    fs_ff;
   logic [6:0]                    hs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= ogru_pkg::CSR_W'(3277);
         fs_ff <= 7'd10;
         hs_ff <= 7'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ogru_pkg::CSR_CELL_SIZE: cs_ff <= csr_wdata;
            ogru_pkg::CSR_FREE_STEP: fs_ff <= csr_wdata[6:0];
            ogru_pkg::CSR_HIT_STEP:  hs_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // input word
   logic                          op_ff;
   logic signed [31:0]            px_ff, py_ff, hx_ff, hy_ff;
   logic [15:0]                   cidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_op;
         px_ff   <= req_pose_x;
         py_ff   <= req_pose_y;
         hx_ff   <= req_point_x;
         hy_ff   <= req_point_y;
         cidx_ff <= req_cell_index;
      end
   end

   // coordinate to index divisions
   logic [1:0]                    sel_ff;
   logic signed [IW-1:0]          pxi_ff, pyi_ff, hxi_ff, hyi_ff;
   logic signed [31:0]            coord;
   logic [31:0]                   coord_mag;
   logic signed [IW-1:0]          idx_new;
   logic [ogru_pkg::DVD_W-1:0]    div_dvd;
   logic [ogru_pkg::DSR_W-1:0]    div_dsr;
   logic [ogru_pkg::DVD_W-1:0]    quot;
   logic                          div_done;
   logic [ogru_pkg::CSR_W-1:0]    cs_eff;

   // ray geometry
   logic                          xmaj_ff;
   logic signed [IW-1:0]          pmaj_ff, pmin_ff, hmaj_ff, hmin_ff;
   logic signed [ogru_pkg::DIFF_W-1:0] dmaj_ff, dmin_ff;
   logic signed [ogru_pkg::DIFF_W-1:0] dx, dy;
   logic [ogru_pkg::DIFF_W-1:0]   adx, ady, dmaj_mag, dmin_mag;
   logic                          xmaj;
   logic signed [ogru_pkg::SLOPE_W-1:0] slope_ff, slope_new;
   logic [16:0]                   q17;

   always_comb begin
      unique case (sel_ff)
         2'd0: coord = px_ff;
         2'd1: coord = py_ff;
         2'd2: coord = hx_ff;
         default: coord = hy_ff;
      endcase
      coord_mag = coord[31] ? 32'(-coord) : 32'(coord);
      idx_new   = coord[31] ? IDX_HALF - $signed({2'b00, quot[31:0]})
                            : IDX_HALF + $signed({2'b00, quot[31:0]});
      cs_eff    = (cs_ff == '0) ? ogru_pkg::CSR_W'(1) : cs_ff;
      dx        = $signed({hx_ff[31], hx_ff}) - $signed({px_ff[31], px_ff});
      dy        = $signed({hy_ff[31], hy_ff}) - $signed({py_ff[31], py_ff});
      adx       = dx[ogru_pkg::DIFF_W-1] ? ogru_pkg::DIFF_W'(-dx) : ogru_pkg::DIFF_W'(dx);
      ady       = dy[ogru_pkg::DIFF_W-1] ? ogru_pkg::DIFF_W'(-dy) : ogru_pkg::DIFF_W'(dy);
      xmaj      = ady < adx;
      dmaj_mag  = dmaj_ff[ogru_pkg::DIFF_W-1] ? ogru_pkg::DIFF_W'(-dmaj_ff)
                                               : ogru_pkg::DIFF_W'(dmaj_ff);
      dmin_mag  = dmin_ff[ogru_pkg::DIFF_W-1] ? ogru_pkg::DIFF_W'(-dmin_ff)
                                               : ogru_pkg::DIFF_W'(dmin_ff);
      if (cmd.slope_start) begin
         div_dvd = {dmin_mag, 16'b0};
         div_dsr = dmaj_mag;
      end else begin
         div_dvd = ogru_pkg::DVD_W'(coord_mag);
         div_dsr = ogru_pkg::DSR_W'(cs_eff);
      end
      q17       = quot[16:0];
      slope_new = (dmin_ff[ogru_pkg::DIFF_W-1] ^ dmaj_ff[ogru_pkg::DIFF_W-1])
                  ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
   end

   ogru_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.coord_start | cmd.slope_start),
      .long_run (cmd.slope_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (cmd.take) begin
         sel_ff <= '0;
      end else if (cmd.coord_store) begin
         sel_ff <= sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.coord_store) begin
         unique case (sel_ff)
            2'd0: pxi_ff <= idx_new;
            2'd1: pyi_ff <= idx_new;
            2'd2: hxi_ff <= idx_new;
            default: hyi_ff <= idx_new;
         endcase
      end
      if (cmd.axis) begin
         xmaj_ff <= xmaj;
         pmaj_ff <= xmaj ? pxi_ff : pyi_ff;
         pmin_ff <= xmaj ? pyi_ff : pxi_ff;
         hmaj_ff <= xmaj ? hxi_ff : hyi_ff;
         hmin_ff <= xmaj ? hyi_ff : hxi_ff;
         dmaj_ff <= xmaj ? dx : dy;
         dmin_ff <= xmaj ? dy : dx;
      end
      if (cmd.slope_store) begin
         slope_ff <= slope_new;
      end
   end

   // walk range
   logic signed [IW-1:0]          w_start, w_end, w_mst, w_lo, w_hi;
   logic                          w_fwd, w_clip;
   logic signed [IW-1:0]          mstart_ff;
   logic [IW-1:0]                 offset_ff;
   logic [AW-1:0]                 j_ff, hi_ff;
   logic                          empty_ff;
   logic signed [ogru_pkg::PROD_W-1:0] prod_ff;
   logic signed [CW-1:0]          acc_ff;

   always_comb begin
      w_fwd   = hmaj_ff > pmaj_ff;
      w_start = w_fwd ? pmaj_ff : hmaj_ff + IDX_ONE;
      w_end   = w_fwd ? hmaj_ff - IDX_ONE : pmaj_ff;
      w_mst   = w_fwd ? pmin_ff : hmin_ff;
      w_lo    = w_start[IW-1] ? '0 : w_start;
      w_hi    = (w_end > IDX_TOP) ? IDX_TOP : w_end;
      w_clip  = w_start[IW-1] || (w_end > IDX_TOP);
   end

   always_ff @(posedge clock) begin
      if (cmd.range) begin
         mstart_ff <= w_mst;
         offset_ff <= IW'(w_lo - w_start);
         j_ff      <= w_lo[AW-1:0];
         hi_ff     <= w_hi[AW-1:0];
         empty_ff  <= w_lo > w_hi;
      end else if (cmd.walk_adv) begin
         j_ff <= j_ff + AW'(1);
      end
      if (cmd.mul) begin
         prod_ff <= ogru_pkg::PROD_W'(slope_ff * $signed({1'b0, offset_ff}));
      end
      if (cmd.acc_init) begin
         acc_ff <= CW'(prod_ff) + (CW'(mstart_ff) <<< 16);
      end else if (cmd.walk_adv) begin
         acc_ff <= acc_ff + CW'(slope_ff);
      end
   end

   // cell addressing
   logic                          cell_in, hit_in, read_ok;
   logic [AW-1:0]                 minor, wx, wy;
   logic [MW-1:0]                 walk_addr, hit_addr, rd_addr;
   logic                          rd_en;

   always_comb begin
      cell_in   = (acc_ff > ACC_LOW) && (acc_ff < ACC_TOP);
      minor     = acc_ff[CW-1] ? '0 : acc_ff[AW+15:16];
      wx        = xmaj_ff ? j_ff : minor;
      wy        = xmaj_ff ? minor : j_ff;
      walk_addr = MW'(wy * ogru_pkg::SIDE + wx);
      hit_in    = !hxi_ff[IW-1] && (hxi_ff <= IDX_TOP) &&
                  !hyi_ff[IW-1] && (hyi_ff <= IDX_TOP);
      hit_addr  = MW'(hyi_ff[AW-1:0] * ogru_pkg::SIDE + hxi_ff[AW-1:0]);
      read_ok   = 32'(cidx_ff) < ogru_pkg::NCELLS;
      rd_en     = (cmd.walk_rd && cell_in) || (cmd.hit_rd && hit_in) ||
                  (cmd.read_rd && read_ok);
      priority if (cmd.walk_rd) begin
         rd_addr = walk_addr;
      end else if (cmd.hit_rd) begin
         rd_addr = hit_addr;
      end else begin
         rd_addr = MW'(cidx_ff);
      end
   end

   // grid memory
   logic signed [7:0]             mem [ogru_pkg::NCELLS];
   logic signed [7:0]             rdata_ff;
   logic [MW-1:0]                 addr_ff;
   logic [MW-1:0]                 clr_ff;
   logic                          we;
   logic [MW-1:0]                 waddr;
   logic signed [7:0]             wdata, free_val, hit_val;
   logic [7:0]                    hit_sum;

   always_comb begin
      if (rdata_ff == ogru_pkg::CELL_UNKNOWN || rdata_ff == ogru_pkg::CELL_FREE) begin
         free_val = ogru_pkg::CELL_FREE;
      end else if ({1'b0, rdata_ff[6:0]} <= {1'b0, fs_ff}) begin
         free_val = ogru_pkg::CELL_FREE;
      end else begin
         free_val = rdata_ff - $signed({1'b0, fs_ff});
      end
      hit_sum = {1'b0, rdata_ff[6:0]} + {1'b0, hs_ff};
      if (rdata_ff == ogru_pkg::CELL_UNKNOWN || rdata_ff == ogru_pkg::CELL_OCC) begin
         hit_val = ogru_pkg::CELL_OCC;
      end else if (hit_sum > 8'(ogru_pkg::CELL_OCC)) begin
         hit_val = ogru_pkg::CELL_OCC;
      end else begin
         hit_val = $signed(hit_sum);
      end
      we    = cmd.clr_wr || cmd.free_wr || cmd.hit_wr;
      waddr = cmd.clr_wr ? clr_ff : addr_ff;
      priority if (cmd.clr_wr) begin
         wdata = ogru_pkg::CELL_UNKNOWN;
      end else if (cmd.free_wr) begin
         wdata = free_val;
      end else begin
         wdata = hit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (cmd.walk_rd || cmd.hit_rd) begin
         addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + MW'(1);
      end
   end

   // result tracking
   localparam int CNT_W_L = ogru_pkg::CNT_W;
   logic [CNT_W_L-1:0]            count_ff;
   logic                          oor_ff;
   logic                          rd_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         count_ff <= '0;
         oor_ff   <= 1'b0;
      end else begin
         if (cmd.free_wr || cmd.hit_wr) begin
            count_ff <= count_ff + CNT_W_L'(1);
         end
         if ((cmd.range && w_clip) || (cmd.walk_rd && !cell_in) ||
             (cmd.hit_rd && !hit_in) || (cmd.read_rd && !read_ok)) begin
            oor_ff <= 1'b1;
         end
      end
      if (cmd.read_rd) begin
         rd_ok_ff <= read_ok;
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic signed [7:0]             rsp_value_ff;
   logic [CNT_W_L-1:0]            rsp_count_ff;
   logic                          rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (op_ff == ogru_pkg::OP_READ) begin
            rsp_value_ff <= rd_ok_ff ? rdata_ff : ogru_pkg::CELL_UNKNOWN;
            rsp_count_ff <= '0;
         end else begin
            rsp_value_ff <= ogru_pkg::CELL_FREE;
            rsp_count_ff <= count_ff;
         end
         rsp_oor_ff <= oor_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cells_updated = rsp_count_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

   always_comb begin
      status.clr_last   = clr_ff == MW'(ogru_pkg::NCELLS - 1);
      status.op_read    = op_ff == ogru_pkg::OP_READ;
      status.div_done   = div_done;
      status.coord_last = sel_ff == 2'd3;
      status.degen      = hmaj_ff == pmaj_ff;
      status.walk_empty = empty_ff;
      status.walk_last  = j_ff == hi_ff;
      status.cell_in    = cell_in;
      status.hit_in     = hit_in;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ===== rtl/ogru_ctrl.sv =====
module ogru_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ogru_pkg::status_type   status,
   output ogru_pkg::cmd_type      cmd
);

   ogru_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogru_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ogru_pkg::S_CLEAR:
            if (status.clr_last) state_in = ogru_pkg::S_IDLE;
         ogru_pkg::S_IDLE:
            if (req_valid) state_in = ogru_pkg::S_COORD_GO;
         ogru_pkg::S_COORD_GO: begin
            state_in = status.op_read ? ogru_pkg::S_READ : ogru_pkg::S_COORD_WAIT;
         end
         ogru_pkg::S_COORD_WAIT:
            if (status.div_done) begin
               state_in = status.coord_last ? ogru_pkg::S_AXIS : ogru_pkg::S_COORD_GO;
            end
         ogru_pkg::S_AXIS:
            state_in = ogru_pkg::S_SLOPE_GO;
         ogru_pkg::S_SLOPE_GO:
            state_in = status.degen ? ogru_pkg::S_HIT_RD : ogru_pkg::S_SLOPE_WAIT;
         ogru_pkg::S_SLOPE_WAIT:
            if (status.div_done) state_in = ogru_pkg::S_RANGE;
         ogru_pkg::S_RANGE:
            state_in = ogru_pkg::S_MUL;
         ogru_pkg::S_MUL:
            state_in = ogru_pkg::S_ACC;
         ogru_pkg::S_ACC:
            state_in = status.walk_empty ? ogru_pkg::S_HIT_RD : ogru_pkg::S_WALK_RD;
         ogru_pkg::S_WALK_RD:
            if (status.cell_in) begin
               state_in = ogru_pkg::S_WALK_WR;
            end else if (status.walk_last) begin
               state_in = ogru_pkg::S_HIT_RD;
            end
         ogru_pkg::S_WALK_WR:
            state_in = status.walk_last ? ogru_pkg::S_HIT_RD : ogru_pkg::S_WALK_RD;
         ogru_pkg::S_HIT_RD:
            state_in = status.hit_in ? ogru_pkg::S_HIT_WR : ogru_pkg::S_DONE;
         ogru_pkg::S_HIT_WR:
            state_in = ogru_pkg::S_DONE;
         ogru_pkg::S_READ:
            state_in = ogru_pkg::S_DONE;
         ogru_pkg::S_DONE:
            if (status.rsp_free) state_in = ogru_pkg::S_IDLE;
         default:
            state_in = ogru_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ogru_pkg::S_CLEAR:      cmd.clr_wr = 1'b1;
         ogru_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ogru_pkg::S_COORD_GO:   cmd.coord_start = !status.op_read;
         ogru_pkg::S_COORD_WAIT: cmd.coord_store = status.div_done;
         ogru_pkg::S_AXIS:       cmd.axis = 1'b1;
         ogru_pkg::S_SLOPE_GO:   cmd.slope_start = !status.degen;
         ogru_pkg::S_SLOPE_WAIT: cmd.slope_store = status.div_done;
         ogru_pkg::S_RANGE:      cmd.range = 1'b1;
         ogru_pkg::S_MUL:        cmd.mul = 1'b1;
         ogru_pkg::S_ACC:        cmd.acc_init = 1'b1;
         ogru_pkg::S_WALK_RD: begin
            cmd.walk_rd  = 1'b1;
            cmd.walk_adv = !status.cell_in;
         end
         ogru_pkg::S_WALK_WR: begin
            cmd.free_wr  = 1'b1;
            cmd.walk_adv = 1'b1;
         end
         ogru_pkg::S_HIT_RD:     cmd.hit_rd = 1'b1;
         ogru_pkg::S_HIT_WR:     cmd.hit_wr = 1'b1;
         ogru_pkg::S_READ:       cmd.read_rd = 1'b1;
         ogru_pkg::S_DONE:       cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== rtl/occupancy_grid_ray_update.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  op, pose_x/y, point_x/y, cell_index
// rsp       out        rsp_valid/rsp_ready  cell_value, cells_updated, out_of_range
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// one word at a time
// a ray's run time is set by the shared serial divider (four 32-step index divisions,
// at most one 49-step slope division), the read-modify-write of each free cell inside the grid
// and a skip step for each free cell outside it
// after reset a clearing pass sets each of the 65025 cells to unknown while req_ready stays low
// a finished word waits in the output register while the next one is taken
module occupancy_grid_ray_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [31:0]                   req_pose_x,
   input  logic signed [31:0]                   req_pose_y,
   input  logic signed [31:0]                   req_point_x,
   input  logic signed [31:0]                   req_point_y,
   input  logic [15:0]                          req_cell_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [7:0]                    rsp_cell_value,
   output logic [8:0]                           rsp_cells_updated,
   output logic                                 rsp_out_of_range,
   input  logic                                 csr_wr_en,
   input  logic [ogru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ogru_pkg::CSR_W-1:0]           csr_wdata
);

   ogru_pkg::cmd_type    cmd;
   ogru_pkg::status_type status;

   ogru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ogru_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_pose_x        (req_pose_x),
      .req_pose_y        (req_pose_y),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_cell_index    (req_cell_index),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cells_updated (rsp_cells_updated),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

// ===== rtl/ogru_chk.sv =====
module ogru_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [7:0]  rsp_cell_value,
   input logic [8:0]         rsp_cells_updated,
   input logic               rsp_out_of_range
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) &&
         $stable(rsp_cells_updated) && $stable(rsp_out_of_range))
      else $error("stalled result changed");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_value >= -8'sd1 && rsp_cell_value <= 8'sd100 &&
         rsp_cells_updated <= 9'd256)
      else $error("result out of range");

endmodule

bind occupancy_grid_ray_update ogru_chk u_ogru_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_cell_value    (rsp_cell_value),
   .rsp_cells_updated (rsp_cells_updated),
   .rsp_out_of_range  (rsp_out_of_range)
);
